// ===== hdl/stx_pkg.sv =====
// ----------------------------------------------------------------------------
// stx_pkg
// Shared types, codes and helpers of the script tokenizer.
// ----------------------------------------------------------------------------
package stx_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int LINE_OUT_BITS = 16;
    localparam int MAX_RESULTS   = 3;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = 2;
    localparam int Q_CW          = 3;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_EOI   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] TYPE_WORD = 2'd0;
    localparam logic [1:0] TYPE_STR  = 2'd1;
    localparam logic [1:0] TYPE_LIT  = 2'd2;

    localparam logic ERR_NEWLINE  = 1'b0;
    localparam logic ERR_NO_QUOTE = 1'b1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [6:0] {
        M_IDLE   = 7'b0000001,
        M_WORD   = 7'b0000010,
        M_QUOTED = 7'b0000100,
        M_SLASH  = 7'b0001000,
        M_LINE   = 7'b0010000,
        M_BLOCK  = 7'b0100000,
        M_STAR   = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  token_type;
        logic [7:0]  char_out;
        logic [15:0] line_number;
        logic        error_code;
        logic        literal_warning;
        logic        last;
    } t_result;

    typedef struct packed {
        t_mode      mode;
        logic       quote;
        logic [1:0] lit;
        logic       line_inc;
        logic       line_clr;
    } t_next;

    function automatic t_result mk_res(input logic [1:0] kind, input logic [1:0] ttype,
                                       input logic [7:0] ch, input logic err,
                                       input logic warn);
        t_result r;
        r.kind            = kind;
        r.token_type      = ttype;
        r.char_out        = ch;
        r.line_number     = '0;
        r.error_code      = err;
        r.literal_warning = warn;
        r.last            = 1'b0;
        return r;
    endfunction

endpackage

// ===== hdl/stx_char_if.sv =====
// ----------------------------------------------------------------------------
// stx_char_if
// Byte channel into the tokenizer: valid/ready with one script byte.
// ----------------------------------------------------------------------------
interface stx_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// ===== hdl/stx_token_if.sv =====
// ----------------------------------------------------------------------------
// stx_token_if
// Result channel out of the tokenizer: valid/ready with one token result.
// ----------------------------------------------------------------------------
interface stx_token_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  token_type;
    logic [7:0]  char_out;
    logic [15:0] line_number;
    logic        error_code;
    logic        literal_warning;
    logic        last;

    modport source (output valid, output kind, output token_type, output char_out,
                    output line_number, output error_code, output literal_warning,
                    output last, input ready);
    modport sink   (input valid, input kind, input token_type, input char_out,
                    input line_number, input error_code, input literal_warning,
                    input last, output ready);
endinterface

// ===== hdl/script_tokenizer.sv =====
// ----------------------------------------------------------------------------
// script_tokenizer
// Byte-serial lexer for scripts with C-style comments and quoted tokens.
// ----------------------------------------------------------------------------
// Usage:
//   i_char carries one script byte per transfer; byte 0 ends a script.
//   o_tok carries one result per transfer: token character, token end,
//   end of input or error, with the line count and a last flag marking
//   the final result caused by a byte.
//   Each byte is decoded combinationally; its results are registered in
//   the result queue and reach o_tok from its head. One byte is taken per
//   cycle as long as each byte yields at most one result and the receiver
//   keeps up. A byte may yield up to three results; these leave one per
//   cycle, while the receiver is ready, from a four-entry result queue,
//   and i_char.ready is held low while more than one result is queued.
//   When the receiver stalls, results wait in the queue and input stops.
//   Reset empties the queue and returns the lexer to idle with line count
//   zero; each end of input returns the lexer to idle with line count zero.
// ----------------------------------------------------------------------------
module script_tokenizer #(
    parameter int LINE_BITS = stx_pkg::LINE_BITS_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    stx_char_if.sink     i_char,
    stx_token_if.source  o_tok
);

    logic                   room;
    logic                   step;
    logic [1:0]             lex_cnt;
    stx_pkg::t_result [2:0] lex_res;
    stx_pkg::t_result       head;
    logic                   head_valid;

    assign i_char.ready = room;
    assign step         = i_char.valid && room;

    stx_lexer #(
        .LINE_BITS (LINE_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (i_char.char_in),
        .o_cnt   (lex_cnt),
        .o_res   (lex_res)
    );

    stx_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (step ? lex_cnt : 2'd0),
        .i_push     (lex_res),
        .i_pop      (o_tok.ready),
        .o_room     (room),
        .o_valid    (head_valid),
        .o_head     (head)
    );

    assign o_tok.valid           = head_valid;
    assign o_tok.kind            = head.kind;
    assign o_tok.token_type      = head.token_type;
    assign o_tok.char_out        = head.char_out;
    assign o_tok.line_number     = head.line_number;
    assign o_tok.error_code      = head.error_code;
    assign o_tok.literal_warning = head.literal_warning;
    assign o_tok.last            = head.last;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_tok.valid)
        else $error("result valid right after reset");

    a_stall_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_char.ready |-> o_tok.valid)
        else $error("input stalled with empty result queue");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && (o_tok.kind == stx_pkg::KIND_EOI ||
                         o_tok.kind == stx_pkg::KIND_ERROR)) |-> o_tok.last)
        else $error("end or error result not marked last");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && !o_tok.ready) |=> (o_tok.valid && $stable(o_tok.kind) &&
                                           $stable(o_tok.last)))
        else $error("stalled result changed");
`endif

endmodule

// ===== hdl/stx_lexer.sv =====
// ----------------------------------------------------------------------------
// stx_lexer
// Lexer state and per-byte decode: up to three results for each byte.
// ----------------------------------------------------------------------------
module stx_lexer #(
    parameter int LINE_BITS = stx_pkg::LINE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_char,
    output logic [1:0]           o_cnt,
    output stx_pkg::t_result [2:0] o_res
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    stx_pkg::t_mode         r_mode;
    logic                   r_quote;
    logic [1:0]             r_lit;
    logic [LINE_BITS-1:0]   r_line;

    stx_pkg::t_next         id_n, wd_n, nx;
    logic                   id_emit;
    stx_pkg::t_result       id_res;
    logic [1:0]             wd_cnt;
    stx_pkg::t_result [1:0] wd_res;
    stx_pkg::t_result [2:0] res;
    logic [1:0]             cnt;
    logic [1:0]             qtype;
    logic                   wchar;
    logic [31:0]            line_ext;
    stx_pkg::t_next         keep;

    function automatic logic word_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == stx_pkg::CH_UNDER ||
               c == stx_pkg::CH_DASH || c == stx_pkg::CH_SLASH ||
               c == stx_pkg::CH_BSLASH || c == stx_pkg::CH_COLON ||
               c == stx_pkg::CH_DOT;
    endfunction

    assign line_ext = 32'(r_line);
    assign wchar    = word_char(i_char);
    assign qtype    = r_quote ? stx_pkg::TYPE_LIT : stx_pkg::TYPE_STR;

    always_comb begin
        keep = '{mode: r_mode, quote: r_quote, lit: r_lit, line_inc: 1'b0,
                 line_clr: 1'b0};

        // between tokens
        id_n    = keep;
        id_n.mode = stx_pkg::M_IDLE;
        id_emit = 1'b0;
        id_res  = stx_pkg::mk_res(stx_pkg::KIND_CHAR, stx_pkg::TYPE_WORD, i_char, 1'b0, 1'b0);
        if (i_char == stx_pkg::CH_NUL) begin
            id_emit = 1'b1;
            id_res  = stx_pkg::mk_res(stx_pkg::KIND_EOI, stx_pkg::TYPE_WORD, 8'd0, 1'b0, 1'b0);
            id_n.quote    = 1'b0;
            id_n.lit      = 2'd0;
            id_n.line_clr = 1'b1;
        end else if (i_char <= stx_pkg::CH_SPACE) begin
            id_n.line_inc = (i_char == stx_pkg::CH_LF);
        end else if (i_char == stx_pkg::CH_DQUOTE || i_char == stx_pkg::CH_SQUOTE) begin
            id_n.mode  = stx_pkg::M_QUOTED;
            id_n.quote = (i_char == stx_pkg::CH_SQUOTE);
            id_n.lit   = 2'd0;
        end else if (i_char == stx_pkg::CH_SLASH) begin
            id_n.mode = stx_pkg::M_SLASH;
        end else begin
            id_emit   = 1'b1;
            id_n.mode = stx_pkg::M_WORD;
        end

        // inside a word
        wd_res[0] = stx_pkg::mk_res(stx_pkg::KIND_CHAR, stx_pkg::TYPE_WORD, i_char, 1'b0, 1'b0);
        wd_res[1] = id_res;
        if (wchar) begin
            wd_cnt    = 2'd1;
            wd_n      = keep;
            wd_n.mode = stx_pkg::M_WORD;
        end else begin
            wd_res[0] = stx_pkg::mk_res(stx_pkg::KIND_END, stx_pkg::TYPE_WORD, 8'd0, 1'b0, 1'b0);
            wd_cnt    = 2'd1 + 2'(id_emit);
            wd_n      = id_n;
        end

        res = '0;
        cnt = 2'd0;
        nx  = keep;
        case (r_mode)
            stx_pkg::M_WORD: begin
                res[0] = wd_res[0];
                res[1] = wd_res[1];
                cnt    = wd_cnt;
                nx     = wd_n;
            end
            stx_pkg::M_SLASH: begin
                if (i_char == stx_pkg::CH_SLASH) begin
                    nx.mode = stx_pkg::M_LINE;
                end else if (i_char == stx_pkg::CH_STAR) begin
                    nx.mode = stx_pkg::M_BLOCK;
                end else begin
                    res[0] = stx_pkg::mk_res(stx_pkg::KIND_CHAR, stx_pkg::TYPE_WORD,
                                             stx_pkg::CH_SLASH, 1'b0, 1'b0);
                    res[1] = wd_res[0];
                    res[2] = wd_res[1];
                    cnt    = wd_cnt + 2'd1;
                    nx     = wd_n;
                end
            end
            stx_pkg::M_QUOTED: begin
                cnt = 2'd1;
                if (i_char == (r_quote ? stx_pkg::CH_SQUOTE : stx_pkg::CH_DQUOTE)) begin
                    res[0]  = stx_pkg::mk_res(stx_pkg::KIND_END, qtype, 8'd0, 1'b0,
                                              r_quote && (r_lit != 2'd1));
                    nx.mode = stx_pkg::M_IDLE;
                end else if (i_char == stx_pkg::CH_NUL) begin
                    res[0] = stx_pkg::mk_res(stx_pkg::KIND_ERROR, qtype, 8'd0,
                                             stx_pkg::ERR_NO_QUOTE, 1'b0);
                    nx = '{mode: stx_pkg::M_IDLE, quote: 1'b0, lit: 2'd0, line_inc: 1'b0,
                           line_clr: 1'b1};
                end else if (i_char == stx_pkg::CH_LF) begin
                    res[0] = stx_pkg::mk_res(stx_pkg::KIND_ERROR, qtype, 8'd0,
                                             stx_pkg::ERR_NEWLINE, 1'b0);
                    nx.line_inc = 1'b1;
                    nx.mode     = stx_pkg::M_IDLE;
                end else begin
                    res[0] = stx_pkg::mk_res(stx_pkg::KIND_CHAR, qtype, i_char, 1'b0, 1'b0);
                    if (r_lit != 2'd2) begin
                        nx.lit = r_lit + 2'd1;
                    end
                end
            end
            stx_pkg::M_LINE: begin
                if (i_char == stx_pkg::CH_NUL) begin
                    res[0] = id_res;
                    cnt    = 2'd1;
                    nx     = id_n;
                end else if (i_char == stx_pkg::CH_LF) begin
                    nx.line_inc = 1'b1;
                    nx.mode     = stx_pkg::M_IDLE;
                end
            end
            stx_pkg::M_BLOCK, stx_pkg::M_STAR: begin
                if (i_char == stx_pkg::CH_NUL) begin
                    res[0] = id_res;
                    cnt    = 2'd1;
                    nx     = id_n;
                end else if (i_char == stx_pkg::CH_SLASH && r_mode == stx_pkg::M_STAR) begin
                    nx.mode = stx_pkg::M_IDLE;
                end else if (i_char == stx_pkg::CH_STAR) begin
                    nx.mode = stx_pkg::M_STAR;
                end else begin
                    nx.line_inc = (i_char == stx_pkg::CH_LF);
                    nx.mode     = stx_pkg::M_BLOCK;
                end
            end
            default: begin
                res[0] = id_res;
                cnt    = 2'(id_emit);
                nx     = id_n;
            end
        endcase

        for (int k = 0; k < stx_pkg::MAX_RESULTS; k++) begin
            res[k].line_number = line_ext[stx_pkg::LINE_OUT_BITS-1:0];
            res[k].last        = (cnt == 2'(k + 1));
        end
    end

    assign o_cnt = cnt;
    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= stx_pkg::M_IDLE;
            r_quote <= 1'b0;
            r_lit   <= 2'd0;
            r_line  <= '0;
        end else if (i_step) begin
            r_mode  <= nx.mode;
            r_quote <= nx.quote;
            r_lit   <= nx.lit;
            if (nx.line_clr) begin
                r_line <= '0;
            end else if (nx.line_inc && r_line != LINE_MAX) begin
                r_line <= r_line + 1'b1;
            end
        end
    end

endmodule

// ===== hdl/stx_queue.sv =====
// ----------------------------------------------------------------------------
// stx_queue
// Result queue: takes up to three results per cycle, delivers one while i_pop is high.
// ----------------------------------------------------------------------------
module stx_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_push_cnt,
    input  stx_pkg::t_result [2:0] i_push,
    input  logic                   i_pop,
    output logic                   o_room,
    output logic                   o_valid,
    output stx_pkg::t_result       o_head
);

    stx_pkg::t_result            r_mem [stx_pkg::Q_DEPTH];
    logic [stx_pkg::Q_AW-1:0]    r_wr, r_rd;
    logic [stx_pkg::Q_CW-1:0]    r_count;
    logic [stx_pkg::Q_CW-1:0]    n_count;
    logic                        pop;

    assign pop     = i_pop && (r_count != '0);
    assign n_count = r_count + stx_pkg::Q_CW'(i_push_cnt) - stx_pkg::Q_CW'(pop);
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= stx_pkg::Q_CW'(stx_pkg::Q_DEPTH - stx_pkg::MAX_RESULTS));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < stx_pkg::MAX_RESULTS; k++) begin
            if (2'(k) < i_push_cnt) begin
                r_mem[r_wr + stx_pkg::Q_AW'(k)] <= i_push[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + stx_pkg::Q_AW'(i_push_cnt);
            r_rd    <= r_rd + stx_pkg::Q_AW'(pop);
            r_count <= n_count;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for script_tokenizer: a directed byte table, then
// random scripts built from words, quoted tokens, comments and broken input.
// Each accepted byte steps a local lexer model; its tokens, or a typed row's
// own, are compared in order to results, under random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int LINE_BITS    = stx_pkg::LINE_BITS_DEF;
    localparam int DIR_LEN      = 25;
    localparam int RAND_MID     = DIR_LEN + 115;
    localparam int RAND_END     = 260;
    localparam int HOLD_AT      = DIR_LEN + 40;
    localparam int HOLD_CYCLES  = 60;
    localparam int CALM_FROM    = DIR_LEN + 150;
    localparam int CALM_TO      = DIR_LEN + 215;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 1_000_000;

    localparam string WORD_SET =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-/\\:.";

    typedef struct packed {
        logic             drain_first;
        logic [7:0]       ch;
        logic             typed;
        stx_pkg::t_result exp;
    } t_row;

    localparam stx_pkg::t_result NO_EXP = '0;

    localparam t_row DIRECTED [DIR_LEN] = '{
        '{1'b0, stx_pkg::CH_NUL, 1'b1,
          {stx_pkg::KIND_EOI, stx_pkg::TYPE_WORD, stx_pkg::CH_NUL, 16'd0, 1'b0, 1'b0, 1'b1}},
        '{1'b0, 8'hFF, 1'b1,
          {stx_pkg::KIND_CHAR, stx_pkg::TYPE_WORD, 8'hFF, 16'd0, 1'b0, 1'b0, 1'b1}},
        '{1'b0, 8'h01, 1'b1,
          {stx_pkg::KIND_END, stx_pkg::TYPE_WORD, stx_pkg::CH_NUL, 16'd0, 1'b0, 1'b0, 1'b1}},
        '{1'b0, stx_pkg::CH_SLASH,  1'b0, NO_EXP},
        '{1'b0, "!",                1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_DQUOTE, 1'b0, NO_EXP},
        '{1'b0, "x",                1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_LF, 1'b1,
          {stx_pkg::KIND_ERROR, stx_pkg::TYPE_STR, stx_pkg::CH_NUL, 16'd0,
           stx_pkg::ERR_NEWLINE, 1'b0, 1'b1}},
        '{1'b0, stx_pkg::CH_SQUOTE, 1'b0, NO_EXP},
        '{1'b0, "a",                1'b0, NO_EXP},
        '{1'b0, "b",                1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_SQUOTE, 1'b1,
          {stx_pkg::KIND_END, stx_pkg::TYPE_LIT, stx_pkg::CH_NUL, 16'd1, 1'b0, 1'b1, 1'b1}},
        '{1'b0, stx_pkg::CH_SLASH,  1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_STAR,   1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_SLASH,  1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_STAR,   1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_SLASH,  1'b0, NO_EXP},
        '{1'b0, "z",                1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_LF,     1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_SLASH,  1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_SLASH,  1'b0, NO_EXP},
        '{1'b0, "c",                1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_LF,     1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_DQUOTE, 1'b0, NO_EXP},
        '{1'b0, stx_pkg::CH_NUL, 1'b1,
          {stx_pkg::KIND_ERROR, stx_pkg::TYPE_STR, stx_pkg::CH_NUL, 16'd3,
           stx_pkg::ERR_NO_QUOTE, 1'b0, 1'b1}}
    };

    logic i_clk;
    logic i_rst_n;

    stx_char_if  ch_if ();
    stx_token_if tok_if ();

    script_tokenizer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (ch_if),
        .o_tok   (tok_if)
    );

    t_row             feed_q [$];
    stx_pkg::t_result tokens_due [$];
    stx_pkg::t_result byte_tokens [$];
    logic             drain_next = 1'b0;
    int               taken = 0;
    int               fails = 0;
    logic             hold_off = 1'b0;
    logic             calm;

    // lexer model state
    stx_pkg::t_mode       lx_mode  = stx_pkg::M_IDLE;
    logic                 q_single = 1'b0;
    logic [LINE_BITS-1:0] lines    = '0;
    logic [1:0]           lit_len  = '0;

    assign calm = (taken >= CALM_FROM) && (taken < CALM_TO);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- lexer model ----------------

    task automatic put(input logic [1:0] kind, input logic [1:0] ttype,
                       input logic [7:0] ch, input logic err, input logic warn);
        stx_pkg::t_result r;
        r.kind            = kind;
        r.token_type      = ttype;
        r.char_out        = ch;
        r.line_number     = 16'(lines);
        r.error_code      = err;
        r.literal_warning = warn;
        r.last            = 1'b0;
        byte_tokens.push_back(r);
    endtask

    task automatic restart_script();
        lx_mode  = stx_pkg::M_IDLE;
        q_single = 1'b0;
        lines    = '0;
        lit_len  = '0;
    endtask

    task automatic bump_line();
        if (lines != '1) lines++;
    endtask

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == stx_pkg::CH_UNDER ||
               c == stx_pkg::CH_DASH || c == stx_pkg::CH_SLASH ||
               c == stx_pkg::CH_BSLASH || c == stx_pkg::CH_COLON ||
               c == stx_pkg::CH_DOT;
    endfunction

    task automatic lex_idle(input logic [7:0] c);
        lx_mode = stx_pkg::M_IDLE;
        if (c == stx_pkg::CH_NUL) begin
            put(stx_pkg::KIND_EOI, stx_pkg::TYPE_WORD, stx_pkg::CH_NUL, 1'b0, 1'b0);
            restart_script();
        end else if (c <= stx_pkg::CH_SPACE) begin
            if (c == stx_pkg::CH_LF) bump_line();
        end else if (c == stx_pkg::CH_DQUOTE || c == stx_pkg::CH_SQUOTE) begin
            lx_mode  = stx_pkg::M_QUOTED;
            q_single = (c == stx_pkg::CH_SQUOTE);
            lit_len  = '0;
        end else if (c == stx_pkg::CH_SLASH) begin
            lx_mode = stx_pkg::M_SLASH;
        end else begin
            put(stx_pkg::KIND_CHAR, stx_pkg::TYPE_WORD, c, 1'b0, 1'b0);
            lx_mode = stx_pkg::M_WORD;
        end
    endtask

    task automatic lex_word(input logic [7:0] c);
        if (is_word_char(c)) begin
            put(stx_pkg::KIND_CHAR, stx_pkg::TYPE_WORD, c, 1'b0, 1'b0);
            lx_mode = stx_pkg::M_WORD;
        end else begin
            put(stx_pkg::KIND_END, stx_pkg::TYPE_WORD, stx_pkg::CH_NUL, 1'b0, 1'b0);
            lex_idle(c);
        end
    endtask

    task automatic lex_byte(input logic [7:0] c);
        logic [1:0] qtype;
        byte_tokens.delete();
        qtype = q_single ? stx_pkg::TYPE_LIT : stx_pkg::TYPE_STR;
        case (lx_mode)
            stx_pkg::M_WORD: begin
                lex_word(c);
            end
            stx_pkg::M_QUOTED: begin
                if (c == (q_single ? stx_pkg::CH_SQUOTE : stx_pkg::CH_DQUOTE)) begin
                    put(stx_pkg::KIND_END, qtype, stx_pkg::CH_NUL, 1'b0,
                        q_single && lit_len != 2'd1);
                    lx_mode = stx_pkg::M_IDLE;
                end else if (c == stx_pkg::CH_NUL) begin
                    put(stx_pkg::KIND_ERROR, qtype, stx_pkg::CH_NUL,
                        stx_pkg::ERR_NO_QUOTE, 1'b0);
                    restart_script();
                end else if (c == stx_pkg::CH_LF) begin
                    put(stx_pkg::KIND_ERROR, qtype, stx_pkg::CH_NUL,
                        stx_pkg::ERR_NEWLINE, 1'b0);
                    bump_line();
                    lx_mode = stx_pkg::M_IDLE;
                end else begin
                    put(stx_pkg::KIND_CHAR, qtype, c, 1'b0, 1'b0);
                    if (lit_len != 2'd2) lit_len++;
                end
            end
            stx_pkg::M_SLASH: begin
                if (c == stx_pkg::CH_SLASH) begin
                    lx_mode = stx_pkg::M_LINE;
                end else if (c == stx_pkg::CH_STAR) begin
                    lx_mode = stx_pkg::M_BLOCK;
                end else begin
                    put(stx_pkg::KIND_CHAR, stx_pkg::TYPE_WORD, stx_pkg::CH_SLASH,
                        1'b0, 1'b0);
                    lex_word(c);
                end
            end
            stx_pkg::M_LINE: begin
                if (c == stx_pkg::CH_NUL) begin
                    put(stx_pkg::KIND_EOI, stx_pkg::TYPE_WORD, stx_pkg::CH_NUL, 1'b0, 1'b0);
                    restart_script();
                end else if (c == stx_pkg::CH_LF) begin
                    bump_line();
                    lx_mode = stx_pkg::M_IDLE;
                end
            end
            stx_pkg::M_BLOCK, stx_pkg::M_STAR: begin
                if (c == stx_pkg::CH_NUL) begin
                    put(stx_pkg::KIND_EOI, stx_pkg::TYPE_WORD, stx_pkg::CH_NUL, 1'b0, 1'b0);
                    restart_script();
                end else if (c == stx_pkg::CH_SLASH && lx_mode == stx_pkg::M_STAR) begin
                    lx_mode = stx_pkg::M_IDLE;
                end else if (c == stx_pkg::CH_STAR) begin
                    lx_mode = stx_pkg::M_STAR;
                end else begin
                    if (c == stx_pkg::CH_LF) bump_line();
                    lx_mode = stx_pkg::M_BLOCK;
                end
            end
            default: begin
                lex_idle(c);
            end
        endcase
        if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
    endtask

    // ---------------- script generation ----------------

    function automatic logic [7:0] pick_byte(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    task automatic add(input logic [7:0] ch);
        feed_q.push_back('{drain_next, ch, 1'b0, NO_EXP});
        drain_next = 1'b0;
    endtask

    task automatic add_quoted(input logic single, input int body, input logic [7:0] tail);
        logic [7:0] q;
        logic [7:0] c;
        q = single ? stx_pkg::CH_SQUOTE : stx_pkg::CH_DQUOTE;
        add(q);
        repeat (body) begin
            c = pick_byte(1, 255);
            if (c == q || c == stx_pkg::CH_LF) c = "q";
            add(c);
        end
        add(tail);
    endtask

    task automatic add_fragment();
        int         r;
        int         n;
        logic       sq;
        logic [7:0] c;
        r  = $urandom_range(99);
        n  = $urandom_range(6);
        sq = 1'($urandom_range(1));
        if (r < 30) begin
            c = $urandom_range(1) ? WORD_SET[$urandom_range(WORD_SET.len() - 1)]
                                  : pick_byte(33, 255);
            if (c == stx_pkg::CH_DQUOTE || c == stx_pkg::CH_SQUOTE) c = "w";
            add(c);
            repeat (n) add(WORD_SET[$urandom_range(WORD_SET.len() - 1)]);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: add(stx_pkg::CH_SPACE);
                5, 6:          add(stx_pkg::CH_LF);
                7, 8:          add(pick_byte(1, 32));
                default:       ;
            endcase
        end else if (r < 45) begin
            add_quoted(1'b0, n, stx_pkg::CH_DQUOTE);
        end else if (r < 58) begin
            add_quoted(1'b1, $urandom_range(3), stx_pkg::CH_SQUOTE);
        end else if (r < 66) begin
            add(stx_pkg::CH_SLASH);
            add(stx_pkg::CH_SLASH);
            repeat (n) begin
                c = pick_byte(1, 255);
                add(c == stx_pkg::CH_LF ? stx_pkg::CH_SPACE : c);
            end
            add($urandom_range(6) == 0 ? stx_pkg::CH_NUL : stx_pkg::CH_LF);
        end else if (r < 74) begin
            add(stx_pkg::CH_SLASH);
            add(stx_pkg::CH_STAR);
            repeat (n) begin
                case ($urandom_range(3))
                    0:       add(stx_pkg::CH_STAR);
                    1:       add(stx_pkg::CH_SLASH);
                    default: add(pick_byte(1, 255));
                endcase
            end
            if ($urandom_range(6) == 0) begin
                add(stx_pkg::CH_NUL);
            end else begin
                add(stx_pkg::CH_STAR);
                add(stx_pkg::CH_SLASH);
            end
        end else if (r < 80) begin
            repeat (n + 1) add(pick_byte(1, 32));
            add(stx_pkg::CH_LF);
        end else if (r < 85) begin
            add_quoted(sq, n, stx_pkg::CH_LF);
        end else if (r < 89) begin
            add_quoted(sq, n, stx_pkg::CH_NUL);
        end else if (r < 95) begin
            repeat ($urandom_range(3, 1)) add(pick_byte(0, 255));
        end else begin
            add(stx_pkg::CH_NUL);
        end
    endtask

    // ---------------- checking ----------------

    function automatic string fmt_token(input stx_pkg::t_result t);
        return $sformatf("kind=%0d type=%0d ch=%02h line=%0d err=%0d warn=%0d last=%0d",
                         t.kind, t.token_type, t.char_out, t.line_number,
                         t.error_code, t.literal_warning, t.last);
    endfunction

    task automatic check_token();
        stx_pkg::t_result got;
        stx_pkg::t_result want;
        got.kind            = tok_if.kind;
        got.token_type      = tok_if.token_type;
        got.char_out        = tok_if.char_out;
        got.line_number     = tok_if.line_number;
        got.error_code      = tok_if.error_code;
        got.literal_warning = tok_if.literal_warning;
        got.last            = tok_if.last;
        if (tokens_due.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected token: %s", fmt_token(got));
        end else begin
            want = tokens_due.pop_front();
            if (got !== want) begin
                fails++;
                if (fails <= 10) begin
                    $display("token mismatch: want %s", fmt_token(want));
                    $display("                got  %s", fmt_token(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (tok_if.valid && tok_if.ready) check_token();
            if (ch_if.valid && ch_if.ready) begin
                lex_byte(ch_if.char_in);
                if (feed_q[taken].typed) begin
                    tokens_due.push_back(feed_q[taken].exp);
                end else begin
                    foreach (byte_tokens[k]) tokens_due.push_back(byte_tokens[k]);
                end
                taken <= taken + 1;
            end
        end
    end

    // ---------------- result side ----------------

    initial begin
        tok_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tok_if.ready <= !hold_off && (calm || $urandom_range(99) >= 22);
        end
    end

    // long receiver stall while bytes keep coming
    initial begin
        wait (taken >= HOLD_AT);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // ---------------- byte side ----------------

    initial begin
        t_row cur;
        i_rst_n       <= 1'b0;
        ch_if.valid   <= 1'b0;
        ch_if.char_in <= '0;

        for (int k = 0; k < DIR_LEN; k++) feed_q.push_back(DIRECTED[k]);
        drain_next = 1'b1;
        while (feed_q.size() < RAND_MID) add_fragment();
        drain_next = 1'b1;
        while (feed_q.size() < RAND_END) add_fragment();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int idx = 0; idx < feed_q.size(); idx++) begin
            cur = feed_q[idx];
            if (cur.drain_first) begin
                ch_if.valid <= 1'b0;
                do @(posedge i_clk); while (tokens_due.size() != 0);
            end
            while (!hold_off && !calm && $urandom_range(99) < 22) begin
                ch_if.valid <= 1'b0;
                @(posedge i_clk);
            end
            ch_if.valid   <= 1'b1;
            ch_if.char_in <= cur.ch;
            do @(posedge i_clk); while (!ch_if.ready);
        end
        ch_if.valid <= 1'b0;

        do @(posedge i_clk); while (tokens_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/stx_pkg.sv
hdl/stx_char_if.sv
hdl/stx_token_if.sv
hdl/stx_lexer.sv
hdl/stx_queue.sv
hdl/script_tokenizer.sv
tb/tb_top.sv
